// File: design/plm_pkg.sv
// Shared types and codes of the positional list engine.
// Depends on nothing; plm_if, plm_seq and the top file refer to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package plm_pkg;

    // Fixed field widths of the request and result channels.
    localparam int REQ_W  = 2;
    localparam int POS_W  = 5;
    localparam int DATA_W = 32;
    localparam int CNT_W  = 5;
    localparam int STAT_W = 2;

    // Request kinds.
    localparam logic [REQ_W-1:0] REQ_GET = 2'd0;
    localparam logic [REQ_W-1:0] REQ_INS = 2'd1;
    localparam logic [REQ_W-1:0] REQ_DEL = 2'd2;
    localparam logic [REQ_W-1:0] REQ_CLR = 2'd3;

    // Result status codes.
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    // One request as seen by the sequencer.
    typedef struct packed {
        logic [REQ_W-1:0]  req_type;
        logic [POS_W-1:0]  position;
        logic [DATA_W-1:0] new_value;
    } t_req;

    // One result as handed from the sequencer to the output register.
    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [DATA_W-1:0] read_value;
        logic [CNT_W-1:0]  entry_count;
    } t_res;

endpackage

`default_nettype wire

// File: design/plm_if.sv
// Valid/ready channel interfaces for requests and results of the list engine.
// Depends on plm_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface plm_req_if;
    logic                       valid;
    logic                       ready;
    logic [plm_pkg::REQ_W-1:0]  req_type;
    logic [plm_pkg::POS_W-1:0]  position;
    logic [plm_pkg::DATA_W-1:0] new_value;

    modport source (output valid, output req_type, output position, output new_value,
                    input ready);
    modport sink   (input valid, input req_type, input position, input new_value,
                    output ready);
endinterface

interface plm_res_if;
    logic                       valid;
    logic                       ready;
    logic [plm_pkg::STAT_W-1:0] status;
    logic [plm_pkg::DATA_W-1:0] read_value;
    logic [plm_pkg::CNT_W-1:0]  entry_count;

    modport source (output valid, output status, output read_value, output entry_count,
                    input ready);
    modport sink   (input valid, input status, input read_value, input entry_count,
                    output ready);
endinterface

`default_nettype wire

// File: design/plm_store.sv
// Entry store of the list engine: one write port and one read port with registered data.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps
`default_nettype none

module plm_store #(
    parameter int DEPTH      = 16,
    parameter int VALUE_BITS = 32
) (
    input  wire                          i_clk,
    input  wire                          i_we,
    input  wire  [$clog2(DEPTH)-1:0]     i_waddr,
    input  wire  [VALUE_BITS-1:0]        i_wdata,
    input  wire  [$clog2(DEPTH)-1:0]     i_raddr,
    output logic [VALUE_BITS-1:0]        o_rdata
);

    logic [VALUE_BITS-1:0] r_mem [DEPTH];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port; the data appears in the cycle after the address.
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// File: design/plm_seq.sv
// Sequencer of the list engine: checks each request and moves entries one per cycle.
// Depends on plm_pkg and drives the ports of plm_store.
`timescale 1ns / 1ps
`default_nettype none

module plm_seq #(
    parameter int DEPTH      = 16,
    parameter int VALUE_BITS = 32
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_req_valid,
    input  wire  plm_pkg::t_req          i_req,
    output logic                         o_req_ready,
    output plm_pkg::t_res                o_res,
    output logic                         o_done,
    input  wire                          i_res_free,
    output logic                         o_we,
    output logic [$clog2(DEPTH)-1:0]     o_waddr,
    output logic [VALUE_BITS-1:0]        o_wdata,
    output logic [$clog2(DEPTH)-1:0]     o_raddr,
    input  wire  [VALUE_BITS-1:0]        i_rdata
);

    localparam int AW   = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > plm_pkg::POS_W) ? CW : plm_pkg::POS_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_GET,
        S_INS,
        S_INS_LAST,
        S_DEL_FIRST,
        S_DEL,
        S_DONE
    } t_state;

    t_state                     r_state, n_state;
    logic [AW-1:0]              r_pos, n_pos;
    logic [AW-1:0]              r_idx, n_idx;
    logic [VALUE_BITS-1:0]      r_val, n_val;
    logic [CW-1:0]              r_count, n_count;
    logic [plm_pkg::STAT_W-1:0] r_status, n_status;
    logic [VALUE_BITS-1:0]      r_rd, n_rd;

    logic [CMPW-1:0] pos_x;
    logic [CMPW-1:0] cnt_x;
    logic [AW-1:0]   pos_a;

    assign pos_x = CMPW'(i_req.position);
    assign cnt_x = CMPW'(r_count);
    assign pos_a = AW'(i_req.position);

    // Next state, bookkeeping and store port control.
    always_comb begin
        n_state  = r_state;
        n_pos    = r_pos;
        n_idx    = r_idx;
        n_val    = r_val;
        n_count  = r_count;
        n_status = r_status;
        n_rd     = r_rd;
        o_we     = 1'b0;
        o_waddr  = r_idx;
        o_wdata  = r_val;
        o_raddr  = r_idx;

        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_pos    = pos_a;
                    n_val    = VALUE_BITS'(i_req.new_value);
                    n_status = plm_pkg::ST_OK;
                    n_rd     = '0;
                    case (i_req.req_type)
                        plm_pkg::REQ_GET: begin
                            if (pos_x >= cnt_x) begin
                                n_status = plm_pkg::ST_RANGE;
                                n_state  = S_DONE;
                            end else begin
                                o_raddr = pos_a;
                                n_state = S_GET;
                            end
                        end
                        plm_pkg::REQ_INS: begin
                            if (pos_x > cnt_x) begin
                                n_status = plm_pkg::ST_RANGE;
                                n_state  = S_DONE;
                            end else if (r_count == CW'(DEPTH)) begin
                                n_status = plm_pkg::ST_FULL;
                                n_state  = S_DONE;
                            end else if (pos_x == cnt_x) begin
                                // Append at the end: nothing to move.
                                o_we    = 1'b1;
                                o_waddr = pos_a;
                                o_wdata = VALUE_BITS'(i_req.new_value);
                                n_count = r_count + CW'(1);
                                n_state = S_DONE;
                            end else begin
                                // Start moving entries up from the last one.
                                o_raddr = AW'(r_count - CW'(1));
                                n_idx   = AW'(r_count - CW'(1));
                                n_state = S_INS;
                            end
                        end
                        plm_pkg::REQ_DEL: begin
                            if (pos_x >= cnt_x) begin
                                n_status = plm_pkg::ST_RANGE;
                                n_state  = S_DONE;
                            end else begin
                                o_raddr = pos_a;
                                n_state = S_DEL_FIRST;
                            end
                        end
                        default: begin
                            n_count = '0;
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_GET: begin
                n_rd    = i_rdata;
                n_state = S_DONE;
            end
            S_INS: begin
                // Entry read last cycle moves one place up.
                o_we    = 1'b1;
                o_waddr = r_idx + AW'(1);
                o_wdata = i_rdata;
                if (r_idx == r_pos) begin
                    n_state = S_INS_LAST;
                end else begin
                    o_raddr = r_idx - AW'(1);
                    n_idx   = r_idx - AW'(1);
                end
            end
            S_INS_LAST: begin
                o_we    = 1'b1;
                o_waddr = r_pos;
                o_wdata = r_val;
                n_count = r_count + CW'(1);
                n_state = S_DONE;
            end
            S_DEL_FIRST: begin
                n_rd = i_rdata;
                if ((CW'(r_pos) + CW'(1)) < r_count) begin
                    o_raddr = r_pos + AW'(1);
                    n_idx   = r_pos + AW'(1);
                    n_state = S_DEL;
                end else begin
                    n_count = r_count - CW'(1);
                    n_state = S_DONE;
                end
            end
            S_DEL: begin
                // Entry read last cycle moves one place down.
                o_we    = 1'b1;
                o_waddr = r_idx - AW'(1);
                o_wdata = i_rdata;
                if ((CW'(r_idx) + CW'(1)) < r_count) begin
                    o_raddr = r_idx + AW'(1);
                    n_idx   = r_idx + AW'(1);
                end else begin
                    n_count = r_count - CW'(1);
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_res_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and registered results.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
        r_pos    <= n_pos;
        r_idx    <= n_idx;
        r_val    <= n_val;
        r_status <= n_status;
        r_rd     <= n_rd;
    end

    assign o_req_ready       = (r_state == S_IDLE);
    assign o_done            = (r_state == S_DONE);
    assign o_res.status      = r_status;
    assign o_res.read_value  = plm_pkg::DATA_W'(r_rd);
    assign o_res.entry_count = plm_pkg::CNT_W'(r_count);

endmodule

`default_nettype wire

// File: design/positional_list_engine.sv
// Positional list engine: ordered list of DEPTH values with get, insert, delete and clear.
// Depends on plm_pkg, plm_if, plm_store and plm_seq.
`timescale 1ns / 1ps
`default_nettype none

// The engine takes one request at a time and is not ready while it works on it.
// A get reads the entry at position p; an insert in the middle moves the entries from p
// up one place, starting with the last, and then writes the new value at p; a delete
// returns the entry at p and moves the later entries down one place. An append, a
// rejected request and a clear move no entries. The entry store moves one entry per cycle
// through its single read and single write port. A result waits in an output register, so a
// new request is taken while the previous result is still pending.
module positional_list_engine #(
    parameter int DEPTH      = 16,
    parameter int VALUE_BITS = 32
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    plm_req_if.sink     i_req,
    plm_res_if.source   o_res
);

    localparam int AW = $clog2(DEPTH);

    plm_pkg::t_req          s_req;
    plm_pkg::t_res          s_res;
    logic                   s_done;
    logic                   s_res_free;
    logic                   s_we;
    logic [AW-1:0]          s_waddr;
    logic [VALUE_BITS-1:0]  s_wdata;
    logic [AW-1:0]          s_raddr;
    logic [VALUE_BITS-1:0]  s_rdata;

    logic                   r_out_valid;
    plm_pkg::t_res          r_out;

    assign s_req.req_type  = i_req.req_type;
    assign s_req.position  = i_req.position;
    assign s_req.new_value = i_req.new_value;

    plm_seq #(
        .DEPTH      (DEPTH),
        .VALUE_BITS (VALUE_BITS)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_req       (s_req),
        .o_req_ready (i_req.ready),
        .o_res       (s_res),
        .o_done      (s_done),
        .i_res_free  (s_res_free),
        .o_we        (s_we),
        .o_waddr     (s_waddr),
        .o_wdata     (s_wdata),
        .o_raddr     (s_raddr),
        .i_rdata     (s_rdata)
    );

    plm_store #(
        .DEPTH      (DEPTH),
        .VALUE_BITS (VALUE_BITS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (s_we),
        .i_waddr (s_waddr),
        .i_wdata (s_wdata),
        .i_raddr (s_raddr),
        .o_rdata (s_rdata)
    );

    // Output register: loads a finished result when empty or being emptied.
    assign s_res_free = !r_out_valid || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_done && s_res_free) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
        if (s_done && s_res_free) begin
            r_out <= s_res;
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.status      = r_out.status;
    assign o_res.read_value  = r_out.read_value;
    assign o_res.entry_count = r_out.entry_count;

`ifndef SYNTHESIS
    // An accepted request always leaves the engine busy in the cycle after acceptance.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> !i_req.ready)
        else $error("engine ready right after accepting a request");

    // A full-list rejection can only occur when the list holds DEPTH entries.
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_done && s_res.status == plm_pkg::ST_FULL) |->
        (s_res.entry_count == plm_pkg::CNT_W'(DEPTH)))
        else $error("full status with a list that is not full");

    // A failed request never returns data.
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_done && s_res.status != plm_pkg::ST_OK) |-> (s_res.read_value == '0))
        else $error("failed request returned a non-zero value");

    // A pending result is not overwritten while it waits.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.ready) |=> (o_res.valid && $stable(r_out)))
        else $error("pending result changed before it was taken");
`endif

endmodule

`default_nettype wire
